// File: design/ffla_pkg.sv
// Shared types, widths and constants of the first-fit lifetime aliasing allocator.
package ffla_pkg;

	localparam int MAX_SLOTS_DEF = 64;
	localparam int KEY_BITS_DEF  = 32;

	localparam int USE_W     = 16;
	localparam int KEY_IN_W  = 32;
	localparam int SIZE_W    = 48;
	localparam int SUM_W     = 56;
	localparam int COUNT_W   = 16;
	localparam int IDX_OUT_W = 6;
	localparam int TOT_OUT_W = 7;

	localparam int S_DATA_W = 120;
	localparam int M_DATA_W = 200;

	localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE,
		ST_TOTAL,
		ST_EMIT
	} state_t;

	// Resource fields broadcast to every cell (key travels apart, its width is a parameter).
	typedef struct packed {
		logic [USE_W-1:0]  first_use;
		logic [USE_W-1:0]  last_use;
		logic              is_buffer;
		logic [SIZE_W-1:0] size_bytes;
	} item_t;

	typedef struct packed {
		logic match_en;
		logic update_en;
		logic alloc_en;
	} cell_ctrl_t;

endpackage

// File: design/ffla_cell.sv
// One allocation slot of the row: stores end, kind, key and size, matches and updates.
module ffla_cell #(
	parameter int IDX      = 0,
	parameter int IW       = 6,
	parameter int CW       = 7,
	parameter int KEY_BITS = ffla_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffla_pkg::cell_ctrl_t        ctrl,
	input  ffla_pkg::item_t             item,
	input  logic [KEY_BITS-1:0]         key,
	input  logic [CW-1:0]               slots_used,
	input  logic                        claim_in,
	input  logic [IW-1:0]               idx_in,
	input  logic [ffla_pkg::SIZE_W-1:0] delta_in,
	output logic                        claim_out,
	output logic [IW-1:0]               idx_out,
	output logic [ffla_pkg::SIZE_W-1:0] delta_out
);

	localparam logic [CW-1:0] MY_CNT = CW'(IDX);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [ffla_pkg::USE_W-1:0]  end_q;
	logic                        kind_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [ffla_pkg::SIZE_W-1:0] size_q;
	logic                        hit_q;

	logic                        win;
	logic                        grow;
	logic                        alloc;
	logic [ffla_pkg::SIZE_W-1:0] diff;

	assign win   = hit_q & ~claim_in;
	assign grow  = item.size_bytes > size_q;
	assign diff  = item.size_bytes - size_q;
	assign alloc = ctrl.alloc_en & (slots_used == MY_CNT);

	// Lowest hit wins: pass the claim on, and let only the winner add its index and growth.
	assign claim_out = claim_in | hit_q;
	assign idx_out   = idx_in | ({IW{win}} & MY_IDX);
	assign delta_out = delta_in | ({ffla_pkg::SIZE_W{win & grow}} & diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.match_en) begin
			hit_q <= (MY_CNT < slots_used) && (end_q < item.first_use) &&
			         (kind_q == item.is_buffer) && (key_q == key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.update_en && win) begin
			end_q <= item.last_use;
			if (grow) begin
				size_q <= item.size_bytes;
			end
		end else if (ctrl.update_en && alloc) begin
			end_q  <= item.last_use;
			kind_q <= item.is_buffer;
			key_q  <= key;
			size_q <= item.size_bytes;
		end
	end

endmodule

// File: design/first_fit_lifetime_aliasing_allocator.sv
// Top level of the first-fit lifetime aliasing allocator: control, totals and the slot row.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata (120 b), s_tuser = is_buffer
//  m_      | out | m_tvalid/m_tready | m_tdata (200 b)
//
// An item passes through accept, match (every cell compares in parallel),
// update (claim passes along the cell row, winner or new slot is written),
// total (physical sum), emit (result word with saved bytes into the output register).
// A new word is taken only in the idle state; the output register holds a
// finished word while the next one is accepted and worked on.
// A stalled output holds the block in the emit state until the word is taken.
// Reset clears the counters and sums; slot contents are only read below the
// slot count, so they need no clearing.
module first_fit_lifetime_aliasing_allocator #(
	parameter int MAX_SLOTS = ffla_pkg::MAX_SLOTS_DEF,
	parameter int KEY_BITS  = ffla_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] starts_plan, [16:1] first_use, [32:17] last_use, [64:33] desc_key,
	// [112:65] size_bytes, [119:113] zero
	input  logic [ffla_pkg::S_DATA_W-1:0] s_tdata,
	// [0] is_buffer
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [5:0] slot_index, [6] reused, [7] overflow, [23:8] resource_total,
	// [30:24] slot_total, [86:31] logical_total, [142:87] physical_total,
	// [198:143] saved_total, [199] zero
	output logic [ffla_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int SW = ffla_pkg::SIZE_W;
	localparam int UW = ffla_pkg::SUM_W;

	ffla_pkg::state_t     state_q, state_d;
	ffla_pkg::cell_ctrl_t ctrl;
	ffla_pkg::item_t      item_q;
	logic [KEY_BITS-1:0]  key_q;

	logic [CW-1:0]                  slots_used_q;
	logic [ffla_pkg::COUNT_W-1:0]   seen_q;
	logic [UW-1:0]                  logical_q;
	logic [UW-1:0]                  physical_q;

	logic [IW-1:0] idx_q;
	logic          reused_q;
	logic          ovf_q;
	logic [SW-1:0] delta_q;

	logic                          m_valid_q;
	logic [ffla_pkg::M_DATA_W-1:0] m_data_q;

	logic          accept;
	logic          out_load;
	logic          full;
	logic          any_hit;
	logic [IW-1:0] chain_idx;
	logic [SW-1:0] chain_delta;

	logic          claim [0:MAX_SLOTS];
	logic [IW-1:0] idx_c [0:MAX_SLOTS];
	logic [SW-1:0] dlt_c [0:MAX_SLOTS];

	logic [KEY_BITS+ffla_pkg::KEY_IN_W-1:0] key_ext;
	logic [UW:0]                            log_sum;
	logic [UW:0]                            phys_sum;
	logic [UW-1:0]                          saved;
	logic [IW+ffla_pkg::IDX_OUT_W-1:0]      idx_ext;
	logic [CW+ffla_pkg::TOT_OUT_W-1:0]      cnt_ext;

	assign accept  = s_tvalid & s_tready;
	assign full    = (slots_used_q == CW'(MAX_SLOTS));
	assign key_ext = {{KEY_BITS{1'b0}}, s_tdata[64:33]};

	// Sequencer: one item at a time, emit waits for a free output register.
	always_comb begin
		state_d        = state_q;
		s_tready       = 1'b0;
		out_load       = 1'b0;
		ctrl.match_en  = 1'b0;
		ctrl.update_en = 1'b0;
		ctrl.alloc_en  = 1'b0;
		case (state_q)
			ffla_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ffla_pkg::ST_MATCH;
				end
			end
			ffla_pkg::ST_MATCH: begin
				ctrl.match_en = 1'b1;
				state_d       = ffla_pkg::ST_UPDATE;
			end
			ffla_pkg::ST_UPDATE: begin
				ctrl.update_en = 1'b1;
				ctrl.alloc_en  = ~any_hit & ~full;
				state_d        = ffla_pkg::ST_TOTAL;
			end
			ffla_pkg::ST_TOTAL: begin
				state_d = ffla_pkg::ST_EMIT;
			end
			ffla_pkg::ST_EMIT: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ffla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffla_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the resource word on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.first_use  <= s_tdata[16:1];
			item_q.last_use   <= s_tdata[32:17];
			item_q.is_buffer  <= s_tuser;
			item_q.size_bytes <= s_tdata[112:65];
			key_q             <= key_ext[KEY_BITS-1:0];
		end
	end

	// Slot row: the claim ripples from slot 0 upwards so the lowest hit wins.
	assign claim[0] = 1'b0;
	assign idx_c[0] = '0;
	assign dlt_c[0] = '0;

	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
		ffla_cell #(
			.IDX      (g),
			.IW       (IW),
			.CW       (CW),
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.item       (item_q),
			.key        (key_q),
			.slots_used (slots_used_q),
			.claim_in   (claim[g]),
			.idx_in     (idx_c[g]),
			.delta_in   (dlt_c[g]),
			.claim_out  (claim[g+1]),
			.idx_out    (idx_c[g+1]),
			.delta_out  (dlt_c[g+1])
		);
	end

	assign any_hit     = claim[MAX_SLOTS];
	assign chain_idx   = idx_c[MAX_SLOTS];
	assign chain_delta = dlt_c[MAX_SLOTS];

	assign log_sum  = {1'b0, logical_q} + (UW+1)'(item_q.size_bytes);
	assign phys_sum = {1'b0, physical_q} + (UW+1)'(delta_q);

	// Counters and sums: clear on a plan start, count and add the logical size while
	// matching, count a new slot, add the physical growth once the slot is settled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q <= '0;
			seen_q       <= '0;
			logical_q    <= '0;
			physical_q   <= '0;
		end else if (accept && s_tdata[0]) begin
			slots_used_q <= '0;
			seen_q       <= '0;
			logical_q    <= '0;
			physical_q   <= '0;
		end else begin
			if (ctrl.match_en) begin
				if (seen_q != ffla_pkg::COUNT_MAX) begin
					seen_q <= seen_q + 1'b1;
				end
				logical_q <= log_sum[UW] ? ffla_pkg::SUM_MAX : log_sum[UW-1:0];
			end
			if (ctrl.alloc_en) begin
				slots_used_q <= slots_used_q + 1'b1;
			end
			if (state_q == ffla_pkg::ST_TOTAL) begin
				physical_q <= phys_sum[UW] ? ffla_pkg::SUM_MAX : phys_sum[UW-1:0];
			end
		end
	end

	// Outcome of the update step.
	always_ff @(posedge clk) begin
		if (ctrl.update_en) begin
			reused_q <= any_hit;
			ovf_q    <= ~any_hit & full;
			if (any_hit) begin
				idx_q   <= chain_idx;
				delta_q <= chain_delta;
			end else if (full) begin
				idx_q   <= '0;
				delta_q <= '0;
			end else begin
				idx_q   <= slots_used_q[IW-1:0];
				delta_q <= item_q.size_bytes;
			end
		end
	end

	assign saved   = (logical_q >= physical_q) ? (logical_q - physical_q) : '0;
	assign idx_ext = {{ffla_pkg::IDX_OUT_W{1'b0}}, idx_q};
	assign cnt_ext = {{ffla_pkg::TOT_OUT_W{1'b0}}, slots_used_q};

	// Output register: hold the word until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {1'b0, saved, physical_q, logical_q,
			             cnt_ext[ffla_pkg::TOT_OUT_W-1:0], seen_q, ovf_q, reused_q,
			             idx_ext[ffla_pkg::IDX_OUT_W-1:0]};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
